// ----- hw/rtl/rwst_pkg.sv -----
`default_nettype none

package rwst_pkg;

	localparam int ADDR_W  = 16;
	localparam int VALUE_W = 16;
	localparam int TIME_W  = 48;
	localparam int SLOT_W  = 3;
	localparam int COUNT_W = 32;

	typedef enum logic [0:0] {
		ACT_RECORD = 1'b0,
		ACT_READ   = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		OUT_HIT   = 2'd0,
		OUT_FREE  = 2'd1,
		OUT_EVICT = 2'd2,
		OUT_READ  = 2'd3
	} outcome_t;

	typedef struct packed {
		action_t             action;
		logic [ADDR_W-1:0]   reg_address;
		logic [VALUE_W-1:0]  reg_value;
		logic [TIME_W-1:0]   time_ms;
		logic [SLOT_W-1:0]   read_slot;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   slot;
		outcome_t            outcome;
		logic [ADDR_W-1:0]   evicted_address;
		logic                slot_valid;
		logic [ADDR_W-1:0]   slot_address;
		logic [VALUE_W-1:0]  slot_value;
		logic [TIME_W-1:0]   slot_time_ms;
		logic [COUNT_W-1:0]  write_count;
	} rsp_t;

endpackage

`default_nettype wire

// ----- hw/rtl/rwst_if.sv -----
`default_nettype none

interface rwst_req_if;
	import rwst_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rwst_rsp_if;
	import rwst_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/register_write_slot_table_lru.sv -----
// Register write slot table with least-recently-written replacement.
//
// req channel (sink): one request per handshake. A record request stores
// reg_address / reg_value / time_ms in a slot: the slot already holding the
// address, else the lowest free slot, else the slot with the oldest timestamp
// (lowest index on a tie). A read request reports slot read_slot.
// rsp channel (source): exactly one response per request, in order, with the
// slot used, the outcome code, the evicted address and the slot contents
// after the request, plus the wrapping count of recorded writes.
//
// Path: a request waits in the request register, and its response is taken
// into the response register as it leaves the stage. Throughput: one request
// per cycle while rsp is not stalled; the lookup, free search and timestamp
// min tree run in the single stage between the request and response registers.
// Reset: all slots invalid, write count zero, both channels empty.
// Stall: while rsp is stalled the request register still fills once, then
// req.ready drops until the response is taken.
`default_nettype none

module register_write_slot_table_lru #(
	parameter int SLOT_COUNT = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	rwst_req_if.sink   req,
	rwst_rsp_if.source rsp
);
	import rwst_pkg::*;

	localparam int IDX_W = $clog2(SLOT_COUNT);

	// request stage
	logic valid_s1;
	req_t req_s1;

	// response register
	logic rsp_valid_q;
	rsp_t rsp_q;
	rsp_t rsp_d;

	logic [COUNT_W-1:0] count_q;

	logic advance;
	logic do_record;
	logic rd_in_range;

	// table interface
	logic               rd_valid;
	logic [ADDR_W-1:0]  rd_address;
	logic [VALUE_W-1:0] rd_value;
	logic [TIME_W-1:0]  rd_time;
	logic [IDX_W-1:0]   rd_idx;
	logic               entry_valid   [SLOT_COUNT];
	logic [ADDR_W-1:0]  entry_address [SLOT_COUNT];
	logic [TIME_W-1:0]  entry_time    [SLOT_COUNT];

	outcome_t         pick_outcome;
	logic [IDX_W-1:0] pick_idx;

	// stage moves on when the response register is empty or being drained
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign do_record = advance && req_s1.action == ACT_RECORD;
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.data;
		end
	end

	rwst_pick #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_pick (
		.address       (req_s1.reg_address),
		.entry_valid   (entry_valid),
		.entry_address (entry_address),
		.entry_time    (entry_time),
		.outcome       (pick_outcome),
		.idx           (pick_idx)
	);

	// the single read port serves the read request or the victim's old address
	assign rd_idx = (req_s1.action == ACT_READ) ? IDX_W'(req_s1.read_slot) : pick_idx;
	assign rd_in_range = 32'(req_s1.read_slot) < SLOT_COUNT;

	// table write lands on the same edge the request leaves the stage, so the
	// next request already sees it
	rwst_table #(
		.SLOT_COUNT(SLOT_COUNT)
	) u_table (
		.clk           (clk),
		.arst_n        (arst_n),
		.wr_en         (do_record),
		.wr_idx        (pick_idx),
		.wr_address    (req_s1.reg_address),
		.wr_value      (req_s1.reg_value),
		.wr_time       (req_s1.time_ms),
		.rd_idx        (rd_idx),
		.rd_valid      (rd_valid),
		.rd_address    (rd_address),
		.rd_value      (rd_value),
		.rd_time       (rd_time),
		.entry_valid   (entry_valid),
		.entry_address (entry_address),
		.entry_time    (entry_time)
	);

	always_comb begin
		rsp_d             = '0;
		rsp_d.write_count = count_q;
		if (req_s1.action == ACT_READ) begin
			rsp_d.slot    = req_s1.read_slot;
			rsp_d.outcome = OUT_READ;
			// slots past the table, and empty slots, report as all zero
			if (rd_in_range && rd_valid) begin
				rsp_d.slot_valid   = 1'b1;
				rsp_d.slot_address = rd_address;
				rsp_d.slot_value   = rd_value;
				rsp_d.slot_time_ms = rd_time;
			end
		end else begin
			rsp_d.slot    = SLOT_W'(pick_idx);
			rsp_d.outcome = pick_outcome;
			if (pick_outcome == OUT_EVICT) begin
				rsp_d.evicted_address = rd_address;
			end
			// contents after the write are the request itself
			rsp_d.slot_valid   = 1'b1;
			rsp_d.slot_address = req_s1.reg_address;
			rsp_d.slot_value   = req_s1.reg_value;
			rsp_d.slot_time_ms = req_s1.time_ms;
			rsp_d.write_count  = count_q + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (do_record) begin
			count_q <= count_q + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

`ifndef SYNTHESIS
	a_record_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.outcome != OUT_READ |-> rsp.data.slot_valid)
		else $error("record response without a valid slot");

	a_evict_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.outcome != OUT_EVICT |-> rsp.data.evicted_address == '0)
		else $error("evicted address set without an eviction");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		do_record |=> count_q == $past(count_q) + COUNT_W'(1))
		else $error("write count did not step on a record");

	a_slot_filled: assert property (@(posedge clk) disable iff (!arst_n)
		do_record |=> entry_valid[$past(pick_idx)])
		else $error("recorded slot not marked valid");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> valid_s1 && rsp_valid_q && !rsp.ready)
		else $error("request side stalled without a full pipeline");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/rwst_table.sv -----
`default_nettype none

module rwst_table #(
	parameter int SLOT_COUNT = 8,
	localparam int IDX_W = $clog2(SLOT_COUNT)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [IDX_W-1:0]              wr_idx,
	input  logic [rwst_pkg::ADDR_W-1:0]   wr_address,
	input  logic [rwst_pkg::VALUE_W-1:0]  wr_value,
	input  logic [rwst_pkg::TIME_W-1:0]   wr_time,
	input  logic [IDX_W-1:0]              rd_idx,
	output logic                          rd_valid,
	output logic [rwst_pkg::ADDR_W-1:0]   rd_address,
	output logic [rwst_pkg::VALUE_W-1:0]  rd_value,
	output logic [rwst_pkg::TIME_W-1:0]   rd_time,
	output logic                          entry_valid [SLOT_COUNT],
	output logic [rwst_pkg::ADDR_W-1:0]   entry_address [SLOT_COUNT],
	output logic [rwst_pkg::TIME_W-1:0]   entry_time [SLOT_COUNT]
);
	import rwst_pkg::*;

	logic               valid_q   [SLOT_COUNT];
	logic [ADDR_W-1:0]  address_q [SLOT_COUNT];
	logic [VALUE_W-1:0] value_q   [SLOT_COUNT];
	logic [TIME_W-1:0]  time_q    [SLOT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (wr_en) begin
			valid_q[wr_idx] <= 1'b1;
		end
	end

	// contents are only looked at behind the valid bit
	always_ff @(posedge clk) begin
		if (wr_en) begin
			address_q[wr_idx] <= wr_address;
			value_q[wr_idx]   <= wr_value;
			time_q[wr_idx]    <= wr_time;
		end
	end

	assign rd_valid   = valid_q[rd_idx];
	assign rd_address = address_q[rd_idx];
	assign rd_value   = value_q[rd_idx];
	assign rd_time    = time_q[rd_idx];

	assign entry_valid   = valid_q;
	assign entry_address = address_q;
	assign entry_time    = time_q;

endmodule

`default_nettype wire

// ----- hw/rtl/rwst_pick.sv -----
`default_nettype none

module rwst_pick #(
	parameter int SLOT_COUNT = 8,
	localparam int IDX_W = $clog2(SLOT_COUNT)
) (
	input  logic [rwst_pkg::ADDR_W-1:0]  address,
	input  logic                         entry_valid [SLOT_COUNT],
	input  logic [rwst_pkg::ADDR_W-1:0]  entry_address [SLOT_COUNT],
	input  logic [rwst_pkg::TIME_W-1:0]  entry_time [SLOT_COUNT],
	output rwst_pkg::outcome_t           outcome,
	output logic [IDX_W-1:0]             idx
);
	import rwst_pkg::*;

	localparam int LEAVES = 1 << IDX_W;
	localparam int NODES  = 2 * LEAVES - 1;

	logic             any_hit;
	logic             any_free;
	logic [IDX_W-1:0] hit_idx;
	logic [IDX_W-1:0] free_idx;

	// heap-ordered min tree: node n has children 2n+1 and 2n+2
	logic              node_ok   [NODES];
	logic [TIME_W-1:0] node_time [NODES];
	logic [IDX_W-1:0]  node_idx  [NODES];

	always_comb begin
		any_hit  = 1'b0;
		any_free = 1'b0;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (entry_valid[i] && entry_address[i] == address) begin
				any_hit = 1'b1;
				hit_idx = IDX_W'(i);
			end
			if (!entry_valid[i]) begin
				any_free = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
		if (i < SLOT_COUNT) begin : g_used
			assign node_ok[LEAVES-1+i]   = 1'b1;
			assign node_time[LEAVES-1+i] = entry_time[i];
			assign node_idx[LEAVES-1+i]  = IDX_W'(i);
		end else begin : g_pad
			assign node_ok[LEAVES-1+i]   = 1'b0;
			assign node_time[LEAVES-1+i] = '0;
			assign node_idx[LEAVES-1+i]  = '0;
		end
	end

	// left child always covers lower indices, so right wins only when strictly older
	for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
		logic take_right;
		assign take_right  = node_ok[2*n+2] &&
			(!node_ok[2*n+1] || node_time[2*n+2] < node_time[2*n+1]);
		assign node_ok[n]   = node_ok[2*n+1] || node_ok[2*n+2];
		assign node_time[n] = take_right ? node_time[2*n+2] : node_time[2*n+1];
		assign node_idx[n]  = take_right ? node_idx[2*n+2] : node_idx[2*n+1];
	end

	always_comb begin
		if (any_hit) begin
			outcome = OUT_HIT;
			idx     = hit_idx;
		end else if (any_free) begin
			outcome = OUT_FREE;
			idx     = free_idx;
		end else begin
			outcome = OUT_EVICT;
			idx     = node_idx[0];
		end
	end

endmodule

`default_nettype wire
